/* src/lswc_pkg.sv */
package lswc_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned WideW    = CoordW + 1;
  localparam int unsigned ProdW    = 2 * WideW;
  localparam int unsigned QuoW     = 2 * CoordW;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_X_MIN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_X_MAX = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_Y_MIN = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_Y_MAX = 2'd3;

  localparam logic signed [CoordW-1:0] X_MIN_RST = 16'sd0;
  localparam logic signed [CoordW-1:0] X_MAX_RST = 16'sd1023;
  localparam logic signed [CoordW-1:0] Y_MIN_RST = 16'sd0;
  localparam logic signed [CoordW-1:0] Y_MAX_RST = 16'sd1023;

  localparam logic signed [CoordW-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [CoordW-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] clipped_start_x;
    logic signed [CoordW-1:0] clipped_start_y;
    logic signed [CoordW-1:0] clipped_end_x;
    logic signed [CoordW-1:0] clipped_end_y;
  } seg_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_min;
    logic signed [CoordW-1:0] x_max;
    logic signed [CoordW-1:0] y_min;
    logic signed [CoordW-1:0] y_max;
  } window_t;

  // what travels alongside the division
  typedef struct packed {
    logic signed [CoordW-1:0] fixed;
    logic signed [CoordW-1:0] base;
    logic                     interp;
    logic                     fix_y;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [QuoW-1:0]   num;
    logic [CoordW-1:0] rem;
    logic [QuoW-1:0]   quo;
    logic [CoordW-1:0] den;
    logic              neg;
    side_t             side;
  } div_st_t;

  // one restoring step: bring down a numerator bit, subtract if it fits
  function automatic div_st_t div_step(div_st_t s);
    div_st_t           r;
    logic [CoordW:0]   rem_w;
    r      = s;
    rem_w  = {s.rem, s.num[QuoW-1]};
    r.num  = {s.num[QuoW-2:0], 1'b0};
    if (rem_w >= {1'b0, s.den}) begin
      rem_w = rem_w - {1'b0, s.den};
      r.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    r.rem = rem_w[CoordW-1:0];
    return r;
  endfunction

endpackage

/* src/line_segment_window_clip.sv */
// Channel  | Direction | Handshake           | Word
// in       | input     | in_valid_i/in_stall_o   | seg_in_t (two endpoints)
// out      | output    | out_valid_o/out_stall_i | seg_out_t (clipped endpoints)
// cfg      | input     | cfg_valid_i/cfg_ready_o | index + window edge
//
// One segment per cycle while the output is not stalled; each endpoint lane holds a
// 32-stage restoring divider that produces one quotient bit per stage.
// Reset clears the valid bits and loads the default window.
// A stalled output word freezes the whole pipeline and stalls the input.
module line_segment_window_clip
  import lswc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  seg_in_t                  in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output seg_out_t                 out_word_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic signed [CoordW-1:0] cfg_data_i
);

  window_t win_q;
  logic    en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.x_min <= X_MIN_RST;
      win_q.x_max <= X_MAX_RST;
      win_q.y_min <= Y_MIN_RST;
      win_q.y_max <= Y_MAX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_X_MIN: win_q.x_min <= cfg_data_i;
        CFG_X_MAX: win_q.x_max <= cfg_data_i;
        CFG_Y_MIN: win_q.y_min <= cfg_data_i;
        CFG_Y_MAX: win_q.y_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                     v_a, v_b;
  logic signed [CoordW-1:0] ax, ay, bx, by;
  logic                     out_valid_q;
  seg_out_t                 out_q;

  // advance unless a finished word is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  lswc_lane u_lane_start (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .win_i   (win_q),
    .p_x_i   (in_word_i.start_x),
    .p_y_i   (in_word_i.start_y),
    .q_x_i   (in_word_i.end_x),
    .q_y_i   (in_word_i.end_y),
    .valid_o (v_a),
    .o_x_o   (ax),
    .o_y_o   (ay)
  );

  lswc_lane u_lane_end (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .win_i   (win_q),
    .p_x_i   (in_word_i.end_x),
    .p_y_i   (in_word_i.end_y),
    .q_x_i   (in_word_i.start_x),
    .q_y_i   (in_word_i.start_y),
    .valid_o (v_b),
    .o_x_o   (bx),
    .o_y_o   (by)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_a & v_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.clipped_start_x <= ax;
      out_q.clipped_start_y <= ay;
      out_q.clipped_end_x   <= bx;
      out_q.clipped_end_y   <= by;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/lswc_div.sv */
module lswc_div
  import lswc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  div_st_t st_i,
  output div_st_t st_o
);

  div_st_t st_q [DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) begin
        st_q[k] <= '0;
      end
    end else if (en_i) begin
      st_q[0] <= div_step(st_i);
      for (int k = 1; k < DivSteps; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
    end
  end

  assign st_o = st_q[DivSteps-1];

endmodule

/* src/lswc_lane.sv */
module lswc_lane
  import lswc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  window_t                  win_i,
  input  logic signed [CoordW-1:0] p_x_i,
  input  logic signed [CoordW-1:0] p_y_i,
  input  logic signed [CoordW-1:0] q_x_i,
  input  logic signed [CoordW-1:0] q_y_i,
  output logic                     valid_o,
  output logic signed [CoordW-1:0] o_x_o,
  output logic signed [CoordW-1:0] o_y_o
);

  logic signed [WideW-1:0] dx, dy, a_d, b_d, den_d;
  side_t                   side_d;

  always_comb begin
    dx          = {q_x_i[CoordW-1], q_x_i} - {p_x_i[CoordW-1], p_x_i};
    dy          = {q_y_i[CoordW-1], q_y_i} - {p_y_i[CoordW-1], p_y_i};
    a_d         = dy;
    b_d         = '0;
    den_d       = dx;
    side_d      = '0;
    side_d.fixed = p_x_i;
    side_d.base  = p_y_i;
    if (dx == '0) begin
      side_d.fix_y = 1'b1;
      side_d.base  = p_x_i;
      if (p_y_i < win_i.y_min)      side_d.fixed = win_i.y_min;
      else if (p_y_i > win_i.y_max) side_d.fixed = win_i.y_max;
      else                          side_d.fixed = p_y_i;
    end else if (dy == '0) begin
      if (p_x_i < win_i.x_min)      side_d.fixed = win_i.x_min;
      else if (p_x_i > win_i.x_max) side_d.fixed = win_i.x_max;
    end else if (p_x_i < win_i.x_min) begin
      side_d.interp = 1'b1;
      side_d.fixed  = win_i.x_min;
      b_d = {win_i.x_min[CoordW-1], win_i.x_min} - {p_x_i[CoordW-1], p_x_i};
    end else if (p_x_i > win_i.x_max) begin
      side_d.interp = 1'b1;
      side_d.fixed  = win_i.x_max;
      b_d = {win_i.x_max[CoordW-1], win_i.x_max} - {p_x_i[CoordW-1], p_x_i};
    end else if (p_y_i < win_i.y_min) begin
      side_d.interp = 1'b1;
      side_d.fix_y  = 1'b1;
      side_d.fixed  = win_i.y_min;
      side_d.base   = p_x_i;
      a_d   = dx;
      den_d = dy;
      b_d = {win_i.y_min[CoordW-1], win_i.y_min} - {p_y_i[CoordW-1], p_y_i};
    end else if (p_y_i > win_i.y_max) begin
      side_d.interp = 1'b1;
      side_d.fix_y  = 1'b1;
      side_d.fixed  = win_i.y_max;
      side_d.base   = p_x_i;
      a_d   = dx;
      den_d = dy;
      b_d = {win_i.y_max[CoordW-1], win_i.y_max} - {p_y_i[CoordW-1], p_y_i};
    end
  end

  // stage 0: operands
  logic                    v0_q;
  logic signed [WideW-1:0] a_q, b_q, den0_q;
  side_t                   side0_q;
  // stage 1: product
  logic                    v1_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [WideW-1:0] den1_q;
  side_t                   side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      b_q     <= b_d;
      den0_q  <= den_d;
      side0_q <= side_d;
      prod_q  <= a_q * b_q;
      den1_q  <= den0_q;
      side1_q <= side0_q;
    end
  end

  logic [ProdW-1:0] prod_mag;
  logic [WideW-1:0] den_mag;
  div_st_t          div_in, div_out;

  always_comb begin
    prod_mag    = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    den_mag     = den1_q[WideW-1] ? WideW'(-den1_q) : WideW'(den1_q);
    div_in       = '0;
    div_in.valid = v1_q;
    div_in.num   = prod_mag[QuoW-1:0];
    div_in.den   = den_mag[CoordW-1:0];
    div_in.neg   = prod_q[ProdW-1] ^ den1_q[WideW-1];
    div_in.side  = side1_q;
  end

  lswc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .st_i   (div_in),
    .st_o   (div_out)
  );

  logic signed [QuoW+1:0]   q_s, sum;
  logic signed [CoordW-1:0] other;
  logic                     vf_q;
  logic signed [CoordW-1:0] ox_q, oy_q;

  always_comb begin
    q_s = div_out.neg ? -$signed({2'b00, div_out.quo}) : $signed({2'b00, div_out.quo});
    sum = $signed({{(QuoW+2-CoordW){div_out.side.base[CoordW-1]}}, div_out.side.base}) + q_s;
    if (!div_out.side.interp)                     other = div_out.side.base;
    else if (sum > $signed((QuoW+2)'(SAT_MAX)))   other = SAT_MAX;
    else if (sum < -$signed((QuoW+2)'(32768)))    other = SAT_MIN;
    else                                          other = sum[CoordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= div_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q <= div_out.side.fix_y ? other : div_out.side.fixed;
      oy_q <= div_out.side.fix_y ? div_out.side.fixed : other;
    end
  end

  assign valid_o = vf_q;
  assign o_x_o   = ox_q;
  assign o_y_o   = oy_q;

endmodule

/* src/lswc_checker.sv */
module lswc_checker
  import lswc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input seg_out_t out_word_o,
  input logic     cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a held output word");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind line_segment_window_clip lswc_checker u_lswc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_ready_o (cfg_ready_o)
);

/* test/line_segment_window_clip_checker.sv */
`timescale 1ns / 100ps
module line_segment_window_clip_checker
  import lswc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  seg_in_t                  in_word_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  seg_out_t                 out_word_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic signed [CoordW-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  window_t  win_q;
  seg_out_t clipped_q[$];
  int       mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = clipped_q.size();

  function automatic longint sat_coord(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic longint clamp_coord(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // move endpoint p of a segment whose other end is q
  function automatic void move_endpoint(longint px, longint py, longint qx, longint qy,
                                        output longint ox, output longint oy);
    longint dx, dy, xl, xh, yl, yh;
    dx = qx - px;
    dy = qy - py;
    xl = win_q.x_min;
    xh = win_q.x_max;
    yl = win_q.y_min;
    yh = win_q.y_max;
    if (dx == 0) begin
      ox = px;
      oy = clamp_coord(py, yl, yh);
    end else if (dy == 0) begin
      oy = py;
      ox = clamp_coord(px, xl, xh);
    end else if (px < xl) begin
      ox = xl;
      oy = sat_coord(py + (dy * (xl - px)) / dx);
    end else if (px > xh) begin
      ox = xh;
      oy = sat_coord(py + (dy * (xh - px)) / dx);
    end else if (py < yl) begin
      oy = yl;
      ox = sat_coord(px + (dx * (yl - py)) / dy);
    end else if (py > yh) begin
      oy = yh;
      ox = sat_coord(px + (dx * (yh - py)) / dy);
    end else begin
      ox = px;
      oy = py;
    end
  endfunction

  function automatic seg_out_t clip_segment(seg_in_t s);
    seg_out_t r;
    longint   x1, y1, x2, y2;
    move_endpoint(s.start_x, s.start_y, s.end_x, s.end_y, x1, y1);
    move_endpoint(s.end_x, s.end_y, s.start_x, s.start_y, x2, y2);
    r.clipped_start_x = x1[15:0];
    r.clipped_start_y = y1[15:0];
    r.clipped_end_x   = x2[15:0];
    r.clipped_end_y   = y2[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    seg_out_t want;
    if (!rst_ni) begin
      win_q <= '{x_min: X_MIN_RST, x_max: X_MAX_RST, y_min: Y_MIN_RST, y_max: Y_MAX_RST};
      clipped_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && !in_stall_i) clipped_q.push_back(clip_segment(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (clipped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word_i);
        end else begin
          want = clipped_q.pop_front();
          if (want !== out_word_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       want.clipped_start_x, want.clipped_start_y,
                       want.clipped_end_x, want.clipped_end_y,
                       out_word_i.clipped_start_x, out_word_i.clipped_start_y,
                       out_word_i.clipped_end_x, out_word_i.clipped_end_y);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_X_MIN: win_q.x_min <= cfg_data_i;
          CFG_X_MAX: win_q.x_max <= cfg_data_i;
          CFG_Y_MIN: win_q.y_min <= cfg_data_i;
          CFG_Y_MAX: win_q.y_max <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/line_segment_window_clip_tb.sv */
`timescale 1ns / 100ps
module line_segment_window_clip_tb;
  import lswc_pkg::*;

  localparam int CycleLimit = 400000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  seg_in_t                  in_word_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  seg_out_t                 out_word_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = CFG_X_MIN;
  logic signed [CoordW-1:0] cfg_data_i = '0;
  int                       fail_count;
  int                       pending;
  int                       cycles = 0;
  int                       send_idle_pct = 34;
  int                       recv_idle_pct = 53;

  always #5 clk_i = ~clk_i;

  line_segment_window_clip DUT (.*);

  line_segment_window_clip_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic signed [15:0] any_coord();
    case ($urandom_range(5))
      0: return 16'sh8000 + 16'($urandom_range(3));
      1: return 16'sh7fff - 16'($urandom_range(3));
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(1300))) - 16'sd150;
    endcase
  endfunction

  task automatic write_edge(logic [CfgIdxW-1:0] idx, logic signed [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(logic signed [15:0] xl, logic signed [15:0] xh,
                            logic signed [15:0] yl, logic signed [15:0] yh);
    // drain and let the pipeline empty before touching the window
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    write_edge(CFG_X_MIN, xl);
    write_edge(CFG_X_MAX, xh);
    write_edge(CFG_Y_MIN, yl);
    write_edge(CFG_Y_MAX, yh);
  endtask

  task automatic send_segment(seg_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(int count);
    seg_in_t s;
    repeat (count) begin
      s = '{any_coord(), any_coord(), any_coord(), any_coord()};
      case ($urandom_range(7))
        0: s.end_x = s.start_x;
        1: s.end_y = s.start_y;
        2: s = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        default: ;
      endcase
      send_segment(s);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, vertical, horizontal, point, each boundary
    send_segment('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    send_segment('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    send_segment('{16'sd5, 16'sh8000, 16'sd5, 16'sh7fff});
    send_segment('{16'sh8000, 16'sd7, 16'sh7fff, 16'sd7});
    send_segment('{16'sd2000, 16'sd2000, 16'sd2000, 16'sd2000});
    send_segment('{-16'sd100, 16'sd50, 16'sd500, 16'sd600});
    send_segment('{16'sd2000, 16'sd50, 16'sd500, 16'sd600});
    send_segment('{16'sd50, -16'sd300, 16'sd600, 16'sd500});
    send_segment('{16'sd50, 16'sd3000, 16'sd600, 16'sd500});
    send_segment('{16'sd10, 16'sd20, 16'sd30, 16'sd40});
    send_segment('{-16'sd1, 16'sd0, 16'sh7fff, 16'sd1});
    send_segment('{16'sh8000, 16'sh7fff, 16'sh7ffe, 16'sh8001});
    send_segment('{16'sd1024, -16'sd1, 16'sh8000, 16'sh7fff});
    in_valid_i <= 1'b0;
    set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_random(15);
    set_window(16'sd500, -16'sd500, 16'sd300, 16'sd100);
    send_random(20);
    set_window(-16'sd100, 16'sd100, -16'sd50, 16'sd50);
    send_random(500);
    send_idle_pct = 53;
    recv_idle_pct = 34;
    set_window(16'sd0, 16'sd1023, 16'sd0, 16'sd1023);
    send_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_random(250);
    set_window(-16'sd3, 16'sd3, 16'sd200, 16'sd900);
    send_random(250);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
